// File: design/buddy_page_allocator_defines.svh
// ----------------------------------------------------------------------------
// buddy page allocator assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// implication checked every clock, muted while in reset
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked every clock, reset included
`define BPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, types and command/status structs of the buddy allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int PAGES      = 1024;
  localparam int MAX_ORDER  = 6;
  localparam int PAGE_BYTES = 4096;

  localparam int PAGE_W = $clog2(PAGES);
  localparam int LINK_W = PAGE_W + 1;
  localparam int ORD_W  = 3;
  localparam int SIZE_W = 32;
  localparam int NLIST  = MAX_ORDER + 1;
  localparam int TOP    = 1 << MAX_ORDER;
  localparam int NTOP   = PAGES / TOP;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ORD_W-1:0]  ord_t;

  localparam link_t NIL       = link_t'(PAGES);
  localparam link_t LAST_TOP  = link_t'((NTOP - 1) * TOP);
  localparam ord_t  ORD_MAX   = ord_t'(MAX_ORDER);
  localparam page_t PAGE_LAST = page_t'(PAGES - 1);

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_UNLINK_A,
    S_UNLINK_B,
    S_SPLIT_LOOP,
    S_SPLIT,
    S_ALLOC_APP2,
    S_ALLOC_FIN,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_LOOP,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_MERGE_B,
    S_FREE_APP1,
    S_FREE_APP2,
    S_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_DECODE,
    OP_UNLINK_A,
    OP_UNLINK_B,
    OP_SPLIT,
    OP_APP2,
    OP_ALLOC_FIN,
    OP_FREE_RD,
    OP_FREE_CHK,
    OP_MERGE_RD,
    OP_MERGE_CHK,
    OP_MERGE_B,
    OP_FREE_APP1,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic dec_ok;
    logic use_set;
    logic buddy_free;
    logic split_more;
    logic below_top;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// page tables, free list heads and tails, and the working registers
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire bpa_pkg::dp_cmd_t         cmd,
  output bpa_pkg::dp_stat_t             stat,
  input  wire logic [bpa_pkg::SIZE_W-1:0] in_size_bytes,
  input  wire bpa_pkg::page_t           in_free_page,
  output logic                          out_ok,
  output bpa_pkg::page_t                out_page_index,
  output bpa_pkg::ord_t                 out_block_order
);
  import bpa_pkg::*;

  // page tables
  ord_t  ord_mem [PAGES];
  logic  use_mem [PAGES];
  link_t nxt_mem [PAGES];
  link_t prv_mem [PAGES];

  ord_t  ord_q;
  logic  use_q;
  link_t nxt_q;
  link_t prv_q;

  link_t first_r [NLIST];
  link_t last_r  [NLIST];
  link_t first_nxt [NLIST];
  link_t last_nxt  [NLIST];

  logic [SIZE_W-1:0] size_r;
  page_t f_r;
  page_t p_r, p_nxt;
  ord_t  o_r, o_nxt;
  ord_t  t_r, t_nxt;
  page_t u_page_r, u_page_nxt;
  ord_t  u_ord_r, u_ord_nxt;
  page_t app_page_r, app_page_nxt;
  ord_t  app_ord_r, app_ord_nxt;
  link_t tail_r, tail_nxt;
  logic  ok_r, ok_nxt;
  page_t clr_cnt_r, clr_cnt_nxt;

  logic  rd_en;
  page_t rd_addr;
  logic  ord_we, use_we, nxt_we, prv_we;
  page_t ord_wa, use_wa, nxt_wa, prv_wa;
  ord_t  ord_wd;
  logic  use_wd;
  link_t nxt_wd, prv_wd;

  // decode of an allocation
  ord_t  want_o, src_o;
  logic  fits, found;
  logic  buddy_free;
  logic  do_unlink;
  ord_t  tn, o_clamp;
  page_t split_b, merge_b, merge_lo;
  logic  clr_top;
  int    ci;

  always_comb begin
    fits   = 1'b0;
    want_o = '0;
    for (int t = 0; t <= MAX_ORDER; t++) begin
      if (!fits && (64'(size_r) <= (64'(PAGE_BYTES) << t))) begin
        fits   = 1'b1;
        want_o = ord_t'(t);
      end
    end
    found = 1'b0;
    src_o = '0;
    for (int t = MAX_ORDER; t >= 0; t--) begin
      if ((ord_t'(t) >= want_o) && (first_r[t] < NIL)) begin
        found = 1'b1;
        src_o = ord_t'(t);
      end
    end
  end

  assign buddy_free = (ord_q == u_ord_r) && !use_q && ({1'b0, u_page_r} < NIL);
  assign do_unlink  = (cmd.op == OP_UNLINK_A) || ((cmd.op == OP_MERGE_CHK) && buddy_free);
  assign tn         = t_r - ord_t'(1);
  assign split_b    = p_r ^ (page_t'(1) << tn);
  assign merge_b    = p_r ^ (page_t'(1) << o_r);
  assign merge_lo   = (u_page_r < p_r) ? u_page_r : p_r;
  assign o_clamp    = (ord_q > ORD_MAX) ? ORD_MAX : ord_q;
  assign ci         = int'(clr_cnt_r);
  assign clr_top    = (clr_cnt_r[MAX_ORDER-1:0] == '0);

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    ord_we       = 1'b0;
    ord_wa       = '0;
    ord_wd       = '0;
    use_we       = 1'b0;
    use_wa       = '0;
    use_wd       = 1'b0;
    nxt_we       = 1'b0;
    nxt_wa       = '0;
    nxt_wd       = NIL;
    prv_we       = 1'b0;
    prv_wa       = '0;
    prv_wd       = NIL;
    first_nxt    = first_r;
    last_nxt     = last_r;
    p_nxt        = p_r;
    o_nxt        = o_r;
    t_nxt        = t_r;
    u_page_nxt   = u_page_r;
    u_ord_nxt    = u_ord_r;
    app_page_nxt = app_page_r;
    app_ord_nxt  = app_ord_r;
    tail_nxt     = tail_r;
    ok_nxt       = ok_r;
    clr_cnt_nxt  = clr_cnt_r;

    unique case (cmd.op)
      OP_NONE, OP_UNLINK_A, OP_MERGE_CHK, OP_EMIT, OP_LATCH: begin
      end
      OP_CLEAR: begin
        ord_we = 1'b1;
        ord_wa = clr_cnt_r;
        ord_wd = clr_top ? ORD_MAX : '0;
        use_we = 1'b1;
        use_wa = clr_cnt_r;
        nxt_we = 1'b1;
        nxt_wa = clr_cnt_r;
        nxt_wd = (clr_top && (ci + 2 * TOP <= PAGES)) ? link_t'(ci + TOP) : NIL;
        prv_we = 1'b1;
        prv_wa = clr_cnt_r;
        prv_wd = (clr_top && (ci > 0) && (ci + TOP <= PAGES)) ? link_t'(ci - TOP) : NIL;
        clr_cnt_nxt = clr_cnt_r + page_t'(1);
      end
      OP_DECODE: begin
        rd_en      = 1'b1;
        rd_addr    = first_r[src_o][PAGE_W-1:0];
        p_nxt      = first_r[src_o][PAGE_W-1:0];
        u_page_nxt = first_r[src_o][PAGE_W-1:0];
        u_ord_nxt  = src_o;
        t_nxt      = src_o;
        o_nxt      = want_o;
      end
      OP_UNLINK_B: begin
        nxt_we = 1'b1;
        nxt_wa = u_page_r;
        prv_we = 1'b1;
        prv_wa = u_page_r;
      end
      OP_SPLIT: begin
        ord_we       = 1'b1;
        ord_wa       = split_b;
        ord_wd       = tn;
        use_we       = 1'b1;
        use_wa       = split_b;
        prv_we       = 1'b1;
        prv_wa       = split_b;
        prv_wd       = last_r[tn];
        nxt_we       = 1'b1;
        nxt_wa       = split_b;
        tail_nxt     = last_r[tn];
        app_page_nxt = split_b;
        app_ord_nxt  = tn;
        t_nxt        = tn;
      end
      OP_APP2: begin
        if (tail_r < NIL) begin
          nxt_we = 1'b1;
          nxt_wa = tail_r[PAGE_W-1:0];
          nxt_wd = {1'b0, app_page_r};
        end else begin
          first_nxt[app_ord_r] = {1'b0, app_page_r};
        end
        last_nxt[app_ord_r] = {1'b0, app_page_r};
      end
      OP_ALLOC_FIN: begin
        ord_we = 1'b1;
        ord_wa = p_r;
        ord_wd = o_r;
        use_we = 1'b1;
        use_wa = p_r;
        use_wd = 1'b1;
        ok_nxt = 1'b1;
      end
      OP_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = f_r;
      end
      OP_FREE_CHK: begin
        if (use_q) begin
          use_we = 1'b1;
          use_wa = f_r;
          p_nxt  = f_r;
          o_nxt  = o_clamp;
          ok_nxt = 1'b1;
        end
      end
      OP_MERGE_RD: begin
        rd_en      = 1'b1;
        rd_addr    = merge_b;
        u_page_nxt = merge_b;
        u_ord_nxt  = o_r;
      end
      OP_MERGE_B: begin
        nxt_we = 1'b1;
        nxt_wa = u_page_r;
        prv_we = 1'b1;
        prv_wa = u_page_r;
        p_nxt  = merge_lo;
        o_nxt  = o_r + ord_t'(1);
        ord_we = 1'b1;
        ord_wa = merge_lo;
        ord_wd = o_r + ord_t'(1);
      end
      OP_FREE_APP1: begin
        prv_we       = 1'b1;
        prv_wa       = p_r;
        prv_wd       = last_r[o_r];
        nxt_we       = 1'b1;
        nxt_wa       = p_r;
        tail_nxt     = last_r[o_r];
        app_page_nxt = p_r;
        app_ord_nxt  = o_r;
      end
      default: begin
      end
    endcase

    // unlink step one: bridge the neighbors of the removed block
    if (do_unlink) begin
      if (prv_q < NIL) begin
        nxt_we = 1'b1;
        nxt_wa = prv_q[PAGE_W-1:0];
        nxt_wd = nxt_q;
      end else begin
        first_nxt[u_ord_r] = nxt_q;
      end
      if (nxt_q < NIL) begin
        prv_we = 1'b1;
        prv_wa = nxt_q[PAGE_W-1:0];
        prv_wd = prv_q;
      end else begin
        last_nxt[u_ord_r] = prv_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_wa] <= ord_wd;
    end
    if (use_we) begin
      use_mem[use_wa] <= use_wd;
    end
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (rd_en) begin
      ord_q <= ord_mem[rd_addr];
      use_q <= use_mem[rd_addr];
      nxt_q <= nxt_mem[rd_addr];
      prv_q <= prv_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NLIST; i++) begin
        first_r[i] <= (i == MAX_ORDER) ? link_t'(0) : NIL;
        last_r[i]  <= (i == MAX_ORDER) ? LAST_TOP : NIL;
      end
      clr_cnt_r <= '0;
      ok_r      <= 1'b0;
    end else begin
      first_r   <= first_nxt;
      last_r    <= last_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      ok_r      <= (cmd.op == OP_LATCH) ? 1'b0 : ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    o_r        <= o_nxt;
    t_r        <= t_nxt;
    u_page_r   <= u_page_nxt;
    u_ord_r    <= u_ord_nxt;
    app_page_r <= app_page_nxt;
    app_ord_r  <= app_ord_nxt;
    tail_r     <= tail_nxt;
    if (cmd.op == OP_LATCH) begin
      size_r <= in_size_bytes;
      f_r    <= in_free_page;
    end
    if (cmd.op == OP_EMIT) begin
      out_ok          <= ok_r;
      out_page_index  <= ok_r ? p_r : '0;
      out_block_order <= ok_r ? o_r : '0;
    end
  end

  assign stat.clr_last   = (clr_cnt_r == PAGE_LAST);
  assign stat.dec_ok     = fits && found;
  assign stat.use_set    = use_q;
  assign stat.buddy_free = buddy_free;
  assign stat.split_more = (t_r > o_r);
  assign stat.below_top  = (o_r < ORD_MAX);

endmodule

`default_nettype wire

// File: design/bpa_control.sv
// ----------------------------------------------------------------------------
// bpa_control
// request sequencer: issues one datapath command per cycle, owns handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_control (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_req_type,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bpa_pkg::dp_cmd_t       cmd,
  input  wire bpa_pkg::dp_stat_t stat
);
  import bpa_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit;

  assign emit = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:      if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (req_t'(in_req_type) == REQ_FREE) ? S_FREE_RD : S_DECODE;
        end
      end
      S_DECODE:     state_nxt = stat.dec_ok ? S_UNLINK_A : S_DONE;
      S_UNLINK_A:   state_nxt = S_UNLINK_B;
      S_UNLINK_B:   state_nxt = S_SPLIT_LOOP;
      S_SPLIT_LOOP: state_nxt = stat.split_more ? S_SPLIT : S_ALLOC_FIN;
      S_SPLIT:      state_nxt = S_ALLOC_APP2;
      S_ALLOC_APP2: state_nxt = S_SPLIT_LOOP;
      S_ALLOC_FIN:  state_nxt = S_DONE;
      S_FREE_RD:    state_nxt = S_FREE_CHK;
      S_FREE_CHK:   state_nxt = stat.use_set ? S_MERGE_LOOP : S_DONE;
      S_MERGE_LOOP: state_nxt = stat.below_top ? S_MERGE_RD : S_FREE_APP1;
      S_MERGE_RD:   state_nxt = S_MERGE_CHK;
      S_MERGE_CHK:  state_nxt = stat.buddy_free ? S_MERGE_B : S_FREE_APP1;
      S_MERGE_B:    state_nxt = S_MERGE_LOOP;
      S_FREE_APP1:  state_nxt = S_FREE_APP2;
      S_FREE_APP2:  state_nxt = S_DONE;
      S_DONE:       if (emit) state_nxt = S_IDLE;
      default:      state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state_r)
      S_CLEAR:      cmd.op = OP_CLEAR;
      S_IDLE:       cmd.op = in_valid ? OP_LATCH : OP_NONE;
      S_DECODE:     cmd.op = OP_DECODE;
      S_UNLINK_A:   cmd.op = OP_UNLINK_A;
      S_UNLINK_B:   cmd.op = OP_UNLINK_B;
      S_SPLIT_LOOP: cmd.op = OP_NONE;
      S_SPLIT:      cmd.op = OP_SPLIT;
      S_ALLOC_APP2: cmd.op = OP_APP2;
      S_ALLOC_FIN:  cmd.op = OP_ALLOC_FIN;
      S_FREE_RD:    cmd.op = OP_FREE_RD;
      S_FREE_CHK:   cmd.op = OP_FREE_CHK;
      S_MERGE_LOOP: cmd.op = OP_NONE;
      S_MERGE_RD:   cmd.op = OP_MERGE_RD;
      S_MERGE_CHK:  cmd.op = OP_MERGE_CHK;
      S_MERGE_B:    cmd.op = OP_MERGE_B;
      S_FREE_APP1:  cmd.op = OP_FREE_APP1;
      S_FREE_APP2:  cmd.op = OP_APP2;
      S_DONE:       cmd.op = emit ? OP_EMIT : OP_NONE;
      default:      cmd.op = OP_NONE;
    endcase
  end

  // result word stays until taken
  assign out_valid_nxt = emit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: design/buddy_page_allocator.sv
// buddy page allocator, 1024 pages, orders 0 to 6, fifo free lists, one word in flight
// allocate: decode, unlink the source block, split down to the wanted order, mark used
// free: check the page is in use, merge free buddies up to order 6, append to a list
// the input opens again in the cycle the result word first shows valid
// after rst_n the page tables are rebuilt, one page a cycle, with in_stall high
// the result register lets the next word in while one waits
// ----------------------------------------------------------------------------
// buddy_page_allocator
// top level: sequencer plus page-table datapath
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_page_allocator_defines.svh"

module buddy_page_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_req_type,
  input  wire logic [bpa_pkg::SIZE_W-1:0] in_size_bytes,
  input  wire bpa_pkg::page_t             in_free_page,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_ok,
  output bpa_pkg::page_t                  out_page_index,
  output bpa_pkg::ord_t                   out_block_order
);
  import bpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bpa_control u_control (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  bpa_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_size_bytes   (in_size_bytes),
    .in_free_page    (in_free_page),
    .out_ok          (out_ok),
    .out_page_index  (out_page_index),
    .out_block_order (out_block_order)
  );

  `BPA_ASSERT(a_one_in_flight, (in_valid && !in_stall) |=> in_stall, "second word taken while busy")
  `BPA_ASSERT(a_refused_zero, (out_valid && !out_ok) |-> (out_page_index == '0 && out_block_order == '0), "refused result not zeroed")
  `BPA_ASSERT(a_order_range, out_valid |-> (out_block_order <= ORD_MAX), "result order out of range")
  `BPA_ASSERT_ALWAYS(a_reset_busy, !rst_n |=> in_stall, "input open right after reset")

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy page allocator testbench
// drives allocate and free words, predicts every reply from a shadow copy of
// the page tables and free lists, and compares the replies in order
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import bpa_pkg::*;

  typedef struct packed {
    logic                 req_type;
    logic [SIZE_W-1:0]    size_bytes;
    page_t                free_page;
  } alloc_req_t;

  typedef struct packed {
    logic  ok;
    page_t page_index;
    ord_t  block_order;
  } alloc_rsp_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_req_type;
  logic [SIZE_W-1:0] in_size_bytes;
  page_t      in_free_page;
  logic       out_valid;
  logic       out_stall;
  logic       out_ok;
  page_t      out_page_index;
  ord_t       out_block_order;

  buddy_page_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_size_bytes(in_size_bytes),
    .in_free_page(in_free_page),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ok(out_ok), .out_page_index(out_page_index),
    .out_block_order(out_block_order)
  );

  // shadow allocator state
  ord_t  sh_order [PAGES];
  logic  sh_used  [PAGES];
  link_t sh_next  [PAGES];
  link_t sh_prev  [PAGES];
  link_t sh_first [NLIST];
  link_t sh_last  [NLIST];

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  page_t      held_pages[$];
  int         errors;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_off;
  bit         stim_done;

  function automatic void list_push(int o, link_t p);
    link_t tl;
    tl = sh_last[o];
    sh_prev[p] = tl;
    sh_next[p] = NIL;
    if (tl < NIL) sh_next[tl] = p;
    else sh_first[o] = p;
    sh_last[o] = p;
  endfunction

  function automatic void list_drop(int o, link_t p);
    link_t pv;
    link_t nx;
    pv = sh_prev[p];
    nx = sh_next[p];
    if (pv < NIL) sh_next[pv] = nx;
    else sh_first[o] = nx;
    if (nx < NIL) sh_prev[nx] = pv;
    else sh_last[o] = pv;
    sh_next[p] = NIL;
    sh_prev[p] = NIL;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < PAGES; i++) begin
      sh_order[i] = (i % TOP == 0) ? ORD_MAX : ord_t'(0);
      sh_used[i] = 1'b0;
      sh_next[i] = NIL;
      sh_prev[i] = NIL;
    end
    for (int i = 0; i < NLIST; i++) begin
      sh_first[i] = NIL;
      sh_last[i] = NIL;
    end
    for (int i = 0; i + TOP <= PAGES; i += TOP) list_push(MAX_ORDER, link_t'(i));
  endfunction

  function automatic alloc_rsp_t allocate_or_free(alloc_req_t r);
    alloc_rsp_t rs;
    int o;
    int t;
    int p;
    int b;
    bit fits;
    rs = '0;
    o = 0;
    fits = 0;
    if (r.req_type == REQ_ALLOC) begin
      for (t = 0; t <= MAX_ORDER; t++)
        if (!fits && 64'(r.size_bytes) <= (64'(PAGE_BYTES) << t)) begin
          o = t;
          fits = 1;
        end
      if (fits) begin
        for (t = o; t <= MAX_ORDER; t++)
          if (sh_first[t] < NIL) break;
        if (t <= MAX_ORDER) begin
          p = sh_first[t];
          list_drop(t, link_t'(p));
          while (t > o) begin
            t--;
            b = p ^ (1 << t);
            sh_order[b] = ord_t'(t);
            sh_used[b] = 1'b0;
            list_push(t, link_t'(b));
          end
          sh_order[p] = ord_t'(o);
          sh_used[p] = 1'b1;
          rs = '{1'b1, page_t'(p), ord_t'(o)};
        end
      end
    end else begin
      p = r.free_page;
      if (sh_used[p]) begin
        sh_used[p] = 1'b0;
        o = sh_order[p];
        if (o > MAX_ORDER) o = MAX_ORDER;
        while (o < MAX_ORDER) begin
          b = p ^ (1 << o);
          if (b >= PAGES || sh_order[b] != o || sh_used[b]) break;
          list_drop(o, link_t'(b));
          if (b < p) p = b;
          o++;
          sh_order[p] = ord_t'(o);
        end
        list_push(o, link_t'(p));
        rs = '{1'b1, page_t'(p), ord_t'(o)};
      end
    end
    return rs;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    int o;
    o = $urandom_range(0, MAX_ORDER);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'(PAGE_BYTES) << o;
      2: return (32'(PAGE_BYTES) << o) + 1;
      default: return $urandom_range(1, PAGE_BYTES << o);
    endcase
  endfunction

  task automatic queue_alloc(logic [SIZE_W-1:0] sz);
    pending_reqs.push_back('{REQ_ALLOC, sz, page_t'($urandom())});
  endtask

  task automatic queue_free(page_t pg);
    pending_reqs.push_back('{REQ_FREE, $urandom(), pg});
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        alloc_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_req_type <= r.req_type;
        in_size_bytes <= r.size_bytes;
        in_free_page <= r.free_page;
        expected_rsps.push_back(allocate_or_free(r));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%t: unexpected word ok=%0d page=%0d order=%0d", $time,
                 out_ok, out_page_index, out_block_order);
        errors++;
      end else begin
        alloc_rsp_t e;
        e = expected_rsps.pop_front();
        if (e.ok !== out_ok) begin
          $display("%t: ok expected %0d actual %0d", $time, e.ok, out_ok);
          errors++;
        end
        if (e.page_index !== out_page_index) begin
          $display("%t: page expected %0d actual %0d", $time, e.page_index,
                   out_page_index);
          errors++;
        end
        if (e.block_order !== out_block_order) begin
          $display("%t: order expected %0d actual %0d", $time, e.block_order,
                   out_block_order);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
  endtask

  // random phase: half allocs, the rest mostly frees of held blocks, some junk frees
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) begin
        logic [SIZE_W-1:0] sz;
        sz = rand_size();
        queue_alloc(sz);
      end else if (k < 90 && held_pages.size() > 0) begin
        int j;
        j = $urandom_range(0, held_pages.size() - 1);
        queue_free(held_pages[j]);
        held_pages.delete(j);
      end else begin
        queue_free(page_t'($urandom()));
      end
    end
  endtask

  // track pages of ok replies, grants and frees alike, as targets for later frees
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_ok && expected_rsps.size() >= 0)
      if ($urandom_range(0, 1) == 0 || held_pages.size() < 8)
        held_pages.push_back(out_page_index);
  end

  initial begin
    errors = 0;
    stim_done = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = 1'b0;
    in_size_bytes = '0;
    in_free_page = '0;
    out_stall = 1'b0;
    shadow_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: size edges, exhaustion, bad frees, merges
    queue_alloc(32'd0);
    queue_alloc(32'd1);
    queue_alloc(32'(PAGE_BYTES));
    queue_alloc(32'(PAGE_BYTES) + 1);
    queue_alloc(32'(PAGE_BYTES << MAX_ORDER));
    queue_alloc(32'(PAGE_BYTES << MAX_ORDER) + 1);
    queue_alloc(32'hFFFF_FFFF);
    queue_free(page_t'(0));
    queue_free(page_t'(0));
    queue_free(page_t'(1));
    queue_free(PAGE_LAST);
    queue_free(page_t'(2));
    queue_free(page_t'(4));
    for (int i = 0; i < NTOP + 1; i++) queue_alloc(32'(PAGE_BYTES << MAX_ORDER));
    queue_alloc(32'd1);
    for (int i = 0; i < NTOP; i++) queue_free(page_t'(i * TOP));
    drain();

    send_idle_pct = 8;
    recv_idle_pct = 62;
    random_phase(170);
    drain();

    send_idle_pct = 62;
    recv_idle_pct = 8;
    random_phase(170);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 400;
    random_phase(170);
    drain();

    repeat (100) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/bpa_pkg.sv
design/bpa_datapath.sv
design/bpa_control.sv
design/buddy_page_allocator.sv
dv/testbench.sv
